@@ rtl/sfrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_pkg: shared types, constants and the CRC-8 step
// Register map, reset values, byte kinds and the per-byte CRC function.
// ----------------------------------------------------------------------------
package sfrc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int POS_W  = 9;

    typedef enum logic [2:0] {
        REG_POLY   = 3'd0,
        REG_INIT   = 3'd1,
        REG_SYNC0  = 3'd2,
        REG_SYNC1  = 3'd3,
        REG_SYNC2  = 3'd4,
        REG_ACK    = 3'd5
    } reg_idx_t;

    localparam logic [7:0] POLY_RST  = 8'hB7;
    localparam logic [7:0] INIT_RST  = 8'hFF;
    localparam logic [7:0] SYNC0_RST = 8'hFE;
    localparam logic [7:0] SYNC1_RST = 8'h55;
    localparam logic [7:0] SYNC2_RST = 8'hAA;
    localparam logic [7:0] ACK_RST   = 8'h66;

    typedef enum logic [2:0] {
        KIND_DISCARD = 3'd0,
        KIND_SYNC    = 3'd1,
        KIND_LENGTH  = 3'd2,
        KIND_BODY    = 3'd3,
        KIND_CHECK   = 3'd4
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] poly;
        logic [7:0] init;
        logic [7:0] sync0;
        logic [7:0] sync1;
        logic [7:0] sync2;
    } cfg_t;

    // MSB-first CRC-8 over one byte, implicit x^8 term
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int b = 0; b < 8; b++) begin
            fb = c[7] ^ data[7 - b];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/sfrc_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_regs: configuration register file
// APB-style write/read of the polynomial, initial value, sync bytes and ack.
// ----------------------------------------------------------------------------
module sfrc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [sfrc_pkg::DATA_W-1:0]   pwdata,
    output logic [sfrc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sfrc_pkg::cfg_t                cfg
);

    logic [7:0] poly_reg;
    logic [7:0] init_reg;
    logic [7:0] sync0_reg;
    logic [7:0] sync1_reg;
    logic [7:0] sync2_reg;
    logic [7:0] ack_reg;
    logic       wr_en;
    logic [2:0] idx;
    logic [7:0] rd_byte;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg  <= sfrc_pkg::POLY_RST;
            init_reg  <= sfrc_pkg::INIT_RST;
            sync0_reg <= sfrc_pkg::SYNC0_RST;
            sync1_reg <= sfrc_pkg::SYNC1_RST;
            sync2_reg <= sfrc_pkg::SYNC2_RST;
            ack_reg   <= sfrc_pkg::ACK_RST;
        end else if (wr_en) begin
            unique case (idx)
                sfrc_pkg::REG_POLY:  poly_reg  <= pwdata[7:0];
                sfrc_pkg::REG_INIT:  init_reg  <= pwdata[7:0];
                sfrc_pkg::REG_SYNC0: sync0_reg <= pwdata[7:0];
                sfrc_pkg::REG_SYNC1: sync1_reg <= pwdata[7:0];
                sfrc_pkg::REG_SYNC2: sync2_reg <= pwdata[7:0];
                sfrc_pkg::REG_ACK:   ack_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            sfrc_pkg::REG_POLY:  rd_byte = poly_reg;
            sfrc_pkg::REG_INIT:  rd_byte = init_reg;
            sfrc_pkg::REG_SYNC0: rd_byte = sync0_reg;
            sfrc_pkg::REG_SYNC1: rd_byte = sync1_reg;
            sfrc_pkg::REG_SYNC2: rd_byte = sync2_reg;
            sfrc_pkg::REG_ACK:   rd_byte = ack_reg;
            default:             rd_byte = 8'h00;
        endcase
    end

    assign prdata = {{(sfrc_pkg::DATA_W - 8){1'b0}}, rd_byte};

    assign cfg.poly  = poly_reg;
    assign cfg.init  = init_reg;
    assign cfg.sync0 = sync0_reg;
    assign cfg.sync1 = sync1_reg;
    assign cfg.sync2 = sync2_reg;

endmodule

@@ rtl/sfrc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_core: frame tracker, CRC and result register
// Tags each byte with offset and kind, runs the CRC, flags good frames.
// ----------------------------------------------------------------------------
module sfrc_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sfrc_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic [sfrc_pkg::POS_W-1:0]    out_pos,
    output sfrc_pkg::byte_kind_t          out_kind,
    output logic                          out_end,
    output logic                          out_good
);

    logic [sfrc_pkg::POS_W-1:0] offset_reg, offset_next;
    logic [7:0]                 length_reg, length_next;
    logic [7:0]                 crc_reg, crc_next;

    logic                       valid_reg, valid_next;
    logic [7:0]                 byte_reg;
    logic [sfrc_pkg::POS_W-1:0] pos_reg, pos_next;
    sfrc_pkg::byte_kind_t       kind_reg, kind_next;
    logic                       end_reg, end_next;
    logic                       good_reg, good_next;

    logic                       fire;
    logic [7:0]                 want;
    logic [7:0]                 crc_base;
    logic [7:0]                 crc_step;
    logic                       at_check;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        case (offset_reg[1:0])
            2'd0:    want = cfg.sync0;
            2'd1:    want = cfg.sync1;
            default: want = cfg.sync2;
        endcase
    end

    assign crc_base = (offset_reg == '0) ? cfg.init : crc_reg;
    assign crc_step = sfrc_pkg::crc8_byte(crc_base, in_byte, cfg.poly);
    assign at_check = {1'b0, offset_reg} >= ({2'b00, length_reg} + 10'd5);

    always_comb begin
        offset_next = offset_reg;
        length_next = length_reg;
        crc_next    = crc_reg;
        pos_next    = offset_reg;
        kind_next   = sfrc_pkg::KIND_BODY;
        end_next    = 1'b0;
        good_next   = 1'b0;
        if (offset_reg <= 9'd2) begin
            if (in_byte != want) begin
                // drop the byte and restart the hunt at the first sync
                offset_next = '0;
                pos_next    = '0;
                kind_next   = sfrc_pkg::KIND_DISCARD;
            end else begin
                kind_next   = sfrc_pkg::KIND_SYNC;
                crc_next    = crc_step;
                offset_next = offset_reg + 9'd1;
            end
        end else if (offset_reg == 9'd3) begin
            kind_next   = sfrc_pkg::KIND_LENGTH;
            length_next = in_byte;
            crc_next    = crc_step;
            offset_next = 9'd4;
        end else if (at_check) begin
            kind_next   = sfrc_pkg::KIND_CHECK;
            end_next    = 1'b1;
            good_next   = (crc_step == 8'h00);
            offset_next = '0;
        end else begin
            crc_next    = crc_step;
            offset_next = offset_reg + 9'd1;
        end
    end

    assign valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            length_reg <= 8'h00;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (fire) begin
                offset_reg <= offset_next;
                length_reg <= length_next;
            end
        end
    end

    // payload: crc is reloaded from cfg.init at every frame start
    always_ff @(posedge aclk) begin
        if (fire) begin
            crc_reg  <= crc_next;
            byte_reg <= in_byte;
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
            end_reg  <= end_next;
            good_reg <= good_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_pos   = pos_reg;
    assign out_kind  = kind_reg;
    assign out_end   = end_reg;
    assign out_good  = good_reg;

endmodule

@@ rtl/sync_frame_receiver_crc8_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc8_unit: CRC-8 checked sync frame receiver
// Tags each received byte with offset and kind; flags good frames.
// Each accepted input word's result word is registered and shown in the following cycle.
// Throughput: 1 word per cycle while m_tready is high, set by the single result register.
// Reset: synchronous active-low aresetn; hunt restarts at first sync byte,
// registers return to their defaults, no result word is pending.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc8_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [sfrc_pkg::DATA_W-1:0]   pwdata,
    output logic [sfrc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [7:0] data_byte, [16:8] position
    output logic [3:0]                    m_tuser,   // [2:0] byte_kind, [3] frame_good
    output logic                          m_tlast    // frame_end
);

    sfrc_pkg::cfg_t             cfg;
    logic [7:0]                 out_byte;
    logic [sfrc_pkg::POS_W-1:0] out_pos;
    sfrc_pkg::byte_kind_t       out_kind;
    logic                       out_good;

    sfrc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfrc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (out_byte),
        .out_pos   (out_pos),
        .out_kind  (out_kind),
        .out_end   (m_tlast),
        .out_good  (out_good)
    );

    assign m_tdata = {7'b0, out_pos, out_byte};
    assign m_tuser = {out_good, out_kind};

    a_last_is_check: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[2:0] == sfrc_pkg::KIND_CHECK)
        else $error("frame end on a byte that is not the check byte");

    a_good_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tlast)
        else $error("frame good outside frame end");

    a_discard_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == sfrc_pkg::KIND_DISCARD |-> m_tdata[16:8] == 9'd0)
        else $error("discarded byte with nonzero position");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register is empty");

endmodule

@@ tb/sfrc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_checker: byte tag predictor and result compare
// Follows register writes on the APB port and every word taken on the input
// stream. Keeps its own hunt/length/CRC state, works out the tag that each
// received byte should get, and compares each result word against it.
// ----------------------------------------------------------------------------
module sfrc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [sfrc_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [23:0]                   m_tdata,
    input  logic [3:0]                    m_tuser,
    input  logic                          m_tlast,
    output int                            mismatches,
    output int                            tags_due
);

    typedef struct packed {
        logic [7:0]           data;
        logic [8:0]           pos;
        sfrc_pkg::byte_kind_t kind;
        logic                 last;
        logic                 good;
    } byte_tag_t;

    logic [7:0] poly;
    logic [7:0] crc_seed;
    logic [7:0] sync_pat [0:2];
    logic [8:0] offset;
    logic [7:0] body_len;
    logic [7:0] crc;
    byte_tag_t  tags_pending [$];
    byte_tag_t  seen;
    byte_tag_t  due;
    int         words_seen;

    initial begin
        mismatches = 0;
        tags_due   = 0;
        words_seen = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] want);
        if (got !== want) begin
            report($sformatf("word %0d %s got %0h expected %0h",
                             words_seen, name, got, want));
        end
    endtask

    // XOR the byte into the register, then shift out eight bits MSB first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc_in,
                                            input logic [7:0] data,
                                            input logic [7:0] gen);
        logic [7:0] r;
        r = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ gen) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // Tag one received byte and advance the frame state
    function automatic byte_tag_t tag_byte(input logic [7:0] b);
        byte_tag_t t;
        t.data = b;
        t.pos  = offset;
        t.kind = sfrc_pkg::KIND_DISCARD;
        t.last = 1'b0;
        t.good = 1'b0;
        if (offset <= 9'd2) begin
            if (b != sync_pat[offset[1:0]]) begin
                // drop back to the hunt; this byte is not tried as a new start
                t.pos  = '0;
                offset = '0;
                crc    = crc_seed;
            end else begin
                t.kind = sfrc_pkg::KIND_SYNC;
                crc    = crc_fold((offset == 9'd0) ? crc_seed : crc, b, poly);
                offset = offset + 9'd1;
            end
        end else if (offset == 9'd3) begin
            t.kind   = sfrc_pkg::KIND_LENGTH;
            body_len = b;
            crc      = crc_fold(crc, b, poly);
            offset   = 9'd4;
        end else if (offset >= {1'b0, body_len} + 9'd5) begin
            t.kind = sfrc_pkg::KIND_CHECK;
            crc    = crc_fold(crc, b, poly);
            t.last = 1'b1;
            t.good = (crc == 8'h00);
            offset = '0;
            crc    = crc_seed;
        end else begin
            t.kind = sfrc_pkg::KIND_BODY;
            crc    = crc_fold(crc, b, poly);
            offset = offset + 9'd1;
        end
        return t;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            poly        = sfrc_pkg::POLY_RST;
            crc_seed    = sfrc_pkg::INIT_RST;
            sync_pat[0] = sfrc_pkg::SYNC0_RST;
            sync_pat[1] = sfrc_pkg::SYNC1_RST;
            sync_pat[2] = sfrc_pkg::SYNC2_RST;
            offset      = '0;
            body_len    = '0;
            crc         = sfrc_pkg::INIT_RST;
            tags_pending.delete();
            tags_due   <= 0;
        end else begin
            // compare before taking a new byte: a result never belongs to
            // the word accepted at the same edge
            if (m_tvalid && m_tready) begin
                seen.data = m_tdata[7:0];
                seen.pos  = m_tdata[16:8];
                seen.kind = sfrc_pkg::byte_kind_t'(m_tuser[2:0]);
                seen.good = m_tuser[3];
                seen.last = m_tlast;
                if (tags_pending.size() == 0) begin
                    report($sformatf("word %0d arrived with no byte waiting, data %0h",
                                     words_seen, seen.data));
                end else begin
                    due = tags_pending.pop_front();
                    check_field("data_byte", 9'(seen.data), 9'(due.data));
                    check_field("position", seen.pos, due.pos);
                    check_field("byte_kind", 9'(seen.kind), 9'(due.kind));
                    check_field("frame_end", 9'(seen.last), 9'(due.last));
                    check_field("frame_good", 9'(seen.good), 9'(due.good));
                end
                words_seen++;
            end
            if (s_tvalid && s_tready) begin
                tags_pending.push_back(tag_byte(s_tdata));
            end
            // register writes act from the next byte on
            if (psel && penable && pwrite && pready) begin
                case (paddr[sfrc_pkg::ADDR_W-1:2])
                    sfrc_pkg::REG_POLY:  poly        = pwdata[7:0];
                    sfrc_pkg::REG_INIT:  crc_seed    = pwdata[7:0];
                    sfrc_pkg::REG_SYNC0: sync_pat[0] = pwdata[7:0];
                    sfrc_pkg::REG_SYNC1: sync_pat[1] = pwdata[7:0];
                    sfrc_pkg::REG_SYNC2: sync_pat[2] = pwdata[7:0];
                    default: ;  // ack code has no result field
                endcase
            end
            tags_due <= tags_pending.size();
        end
    end

endmodule

@@ tb/sync_frame_receiver_crc8_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc8_unit_tb: stimulus and verdict for the frame receiver
// Feeds sync hunts, good and corrupted frames, broken sync runs and noise
// through several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc8_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_BYTES = 30;
    localparam int PHASES      = 6;

    typedef enum {CFG_RANDOM, CFG_ZEROS, CFG_ONES} cfg_mode_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sfrc_pkg::ADDR_W-1:0]   paddr;
    logic [sfrc_pkg::DATA_W-1:0]   pwdata;
    logic [sfrc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;     // [7:0] rx_byte
    logic                          m_tvalid;
    logic                          m_tready;
    logic [23:0]                   m_tdata;     // [7:0] data_byte, [16:8] position
    logic [3:0]                    m_tuser;     // [2:0] byte_kind, [3] frame_good
    logic                          m_tlast;     // frame_end

    int         mismatches;
    int         tags_due;
    int         cycles = 0;
    int         bytes_sent = 0;
    int         holds_asked = 0;
    int         holds_done = 0;
    bit         tx_idle_on;
    bit         rx_idle_on;
    logic [7:0] reg_val [0:sfrc_pkg::REG_ACK];

    sync_frame_receiver_crc8_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sfrc_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .tags_due   (tags_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (holds_done != holds_asked) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Builds good check bytes for the frames sent
    function automatic logic [7:0] crc_roll(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            if (r[7] ^ d[i]) begin
                r = {r[6:0], 1'b0} ^ reg_val[sfrc_pkg::REG_POLY];
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Drop valid and hold until every word sent has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tags_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input sfrc_pkg::reg_idx_t r, input logic [7:0] v);
        reg_val[r] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input cfg_mode_t mode);
        logic [7:0] v;
        for (int i = sfrc_pkg::REG_POLY; i <= sfrc_pkg::REG_ACK; i++) begin
            case (mode)
                CFG_ZEROS: v = 8'h00;
                CFG_ONES:  v = 8'hFF;
                default:   v = 8'($urandom_range(0, 255));
            endcase
            write_reg(sfrc_pkg::reg_idx_t'(i), v);
        end
    endtask

    // A length byte of len carries len+1 body bytes before the check byte
    task automatic send_frame(input int len, input bit spoil);
        logic [7:0] c;
        logic [7:0] b;
        c = reg_val[sfrc_pkg::REG_INIT];
        for (int i = 0; i < 3; i++) begin
            b = reg_val[sfrc_pkg::REG_SYNC0 + i];
            c = crc_roll(c, b);
            put_byte(b);
        end
        b = len[7:0];
        c = crc_roll(c, b);
        put_byte(b);
        for (int i = 0; i <= len; i++) begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            c = crc_roll(c, b);
            put_byte(b);
        end
        // residue is zero only when the check byte equals the running CRC
        put_byte(spoil ? c ^ 8'($urandom_range(1, 255)) : c);
    endtask

    // Valid sync prefix, then a byte that breaks it
    task automatic send_broken();
        int         depth;
        logic [7:0] b;
        depth = $urandom_range(0, 2);
        for (int i = 0; i < depth; i++) begin
            put_byte(reg_val[sfrc_pkg::REG_SYNC0 + i]);
        end
        b = 8'($urandom_range(0, 255));
        if (b == reg_val[sfrc_pkg::REG_SYNC0 + depth]) begin
            b = ~b;
        end
        put_byte(b);
    endtask

    task automatic random_mix(input int goal);
        int pick;
        int len;
        while (bytes_sent < goal) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(0, 12);
                send_frame(len, $urandom_range(0, 3) == 0);
            end else if (pick < 17) begin
                send_broken();
            end else begin
                repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        reg_val[sfrc_pkg::REG_POLY]  = sfrc_pkg::POLY_RST;
        reg_val[sfrc_pkg::REG_INIT]  = sfrc_pkg::INIT_RST;
        reg_val[sfrc_pkg::REG_SYNC0] = sfrc_pkg::SYNC0_RST;
        reg_val[sfrc_pkg::REG_SYNC1] = sfrc_pkg::SYNC1_RST;
        reg_val[sfrc_pkg::REG_SYNC2] = sfrc_pkg::SYNC2_RST;
        reg_val[sfrc_pkg::REG_ACK]   = sfrc_pkg::ACK_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hunt: extremes that miss the first sync byte
        put_byte(8'h00);
        put_byte(8'hFF);
        // miss on the second sync byte; the repeated first byte is not a new start
        put_byte(sfrc_pkg::SYNC0_RST);
        put_byte(sfrc_pkg::SYNC0_RST);
        put_byte(sfrc_pkg::SYNC1_RST);
        // miss on the third sync byte
        put_byte(sfrc_pkg::SYNC0_RST);
        put_byte(sfrc_pkg::SYNC1_RST);
        put_byte(8'h00);
        // zero length good and bad, then a short body
        send_frame(0, 1'b0);
        send_frame(0, 1'b1);
        send_frame(2, 1'b0);
        // longest frame: check byte at position 260, the highest that a frame reaches
        send_frame(255, 1'b0);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            set_config((p == 1) ? CFG_ZEROS : (p == 2) ? CFG_ONES : CFG_RANDOM);
            if (p == 1) begin
                holds_asked <= holds_asked + 1;
            end
            if (p == PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
            end
            random_mix(bytes_sent + PHASE_BYTES);
            settle();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sfrc_pkg.sv
rtl/sfrc_regs.sv
rtl/sfrc_core.sv
rtl/sync_frame_receiver_crc8_unit.sv
tb/sfrc_checker.sv
tb/sync_frame_receiver_crc8_unit_tb.sv
